>>> sv/easp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easp_pkg
// Widths, reset values, speed gain and limit, and register indexes of the encoder speed estimator.
// ----------------------------------------------------------------------------
package easp_pkg;

    localparam int ANGLE_W = 12;
    localparam int TIMER_W = 16;
    localparam int SPEED_W = 22;
    localparam int TURN_W  = 16;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 2;

    localparam int NUM_W   = 23;
    localparam int DEN_W   = 18;
    localparam int CNT_W   = 5;

    localparam logic [NUM_W-1:0]   SPEED_GAIN = NUM_W'(2000);
    localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(1566000);

    localparam logic [CFG_W-1:0]  FULL_TURN_RST = CFG_W'(3600);
    localparam logic [CFG_W-1:0]  WRAP_THR_RST  = CFG_W'(1250);
    localparam logic [CFG_W-1:0]  MIN_STEP_RST  = CFG_W'(30);
    localparam logic [CFG_W-1:0]  MAX_JUMP_RST  = CFG_W'(200);
    localparam logic [TURN_W-1:0] TURN_RST      = TURN_W'(32000);

    typedef enum logic [IDX_W-1:0] {
        CFG_FULL_TURN = 2'd0,
        CFG_WRAP_THR  = 2'd1,
        CFG_MIN_STEP  = 2'd2,
        CFG_MAX_JUMP  = 2'd3
    } cfg_idx_t;

endpackage

>>> sv/encoder_angle_speed_estimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_angle_speed_estimator_core
// Absolute encoder speed and turn count estimator with bit-serial divider.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A sample is taken when s_ready is high. S_STEP
// does step and wrap, S_JUMP the jump check, S_LOAD the divider load; then a
// restoring divider gives one quotient bit per cycle and S_FIN saturation and
// sign before the m_ result beat; a step below min_step skips from S_JUMP to
// a zero-speed result. One sample is held at a time; s_ready returns the
// cycle after the result beat is taken. The user must write registers through
// cfg_we / cfg_idx / cfg_data while no sample is in flight (not enforced).
// ----------------------------------------------------------------------------
module encoder_angle_speed_estimator_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [easp_pkg::IDX_W-1:0]          cfg_idx,
    input  logic [easp_pkg::CFG_W-1:0]          cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [easp_pkg::ANGLE_W-1:0]        s_prev_angle,
    input  logic [easp_pkg::ANGLE_W-1:0]        s_new_angle,
    input  logic [easp_pkg::TIMER_W-1:0]        s_timer_now,
    input  logic                                s_reverse,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [easp_pkg::SPEED_W-1:0] m_speed,
    output logic [easp_pkg::TURN_W-1:0]         m_turn_count,
    output logic                                m_below_min
);
    import easp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_JUMP,
        S_LOAD,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

    state_t               state_reg;

    logic [CFG_W-1:0]     full_turn_reg;
    logic [CFG_W-1:0]     wrap_thr_reg;
    logic [CFG_W-1:0]     min_step_reg;
    logic [CFG_W-1:0]     max_jump_reg;

    logic [TIMER_W-1:0]   last_timer_reg;
    logic [ANGLE_W-1:0]   last_step_reg;
    logic [TURN_W-1:0]    turn_counter_reg;

    logic [TIMER_W-1:0]   dt_reg;
    logic [ANGLE_W-1:0]   d_reg;
    logic                 up_reg;
    logic                 rev_reg;
    logic [ANGLE_W-1:0]   step_reg;

    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic signed [SPEED_W-1:0] speed_reg;
    logic                 below_reg;

    logic                 s_fire;
    logic                 up_in;
    logic                 timer_ahead;
    logic [TIMER_W-1:0]   dt_in;
    logic [ANGLE_W-1:0]   d_in;
    logic [ANGLE_W-1:0]   step_in;
    logic                 wrap;
    logic                 below;
    logic [ANGLE_W-1:0]   jump_diff;
    logic [ANGLE_W-1:0]   step_sel;
    logic [DEN_W:0]       rem_shift;
    logic [DEN_W:0]       rem_sub;
    logic                 q_bit;
    logic [DEN_W-1:0]     rem_next;
    logic [NUM_W-1:0]     num_next;
    logic [SPEED_W-1:0]   mag;

    assign s_ready      = (state_reg == S_IDLE);
    assign s_fire       = s_valid && s_ready;
    assign m_valid      = (state_reg == S_OUT);
    assign m_speed      = speed_reg;
    assign m_turn_count = turn_counter_reg;
    assign m_below_min  = below_reg;

    always_comb begin
        up_in       = s_new_angle > s_prev_angle;
        d_in        = up_in ? s_new_angle - s_prev_angle : s_prev_angle - s_new_angle;
        timer_ahead = s_timer_now > last_timer_reg;
        // non-advancing timer: 0xFFFF + now - last, i.e. one less than the raw difference
        dt_in       = s_timer_now - last_timer_reg - TIMER_W'(!timer_ahead);

        wrap        = d_reg > wrap_thr_reg;
        step_in     = wrap ? full_turn_reg - d_reg : d_reg;

        below       = step_reg < min_step_reg;
        jump_diff   = (step_reg > last_step_reg) ? step_reg - last_step_reg
                                                 : last_step_reg - step_reg;
        step_sel    = (jump_diff > max_jump_reg) ? last_step_reg : step_reg;

        // restoring step; a zero divisor yields all ones, which saturates
        rem_shift   = {rem_reg, num_reg[NUM_W-1]};
        rem_sub     = rem_shift - {1'b0, den_reg};
        q_bit       = !rem_sub[DEN_W];
        rem_next    = q_bit ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        num_next    = {num_reg[NUM_W-2:0], q_bit};

        mag         = (num_reg > NUM_W'(SPEED_MAX)) ? SPEED_MAX : num_reg[SPEED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            full_turn_reg    <= FULL_TURN_RST;
            wrap_thr_reg     <= WRAP_THR_RST;
            min_step_reg     <= MIN_STEP_RST;
            max_jump_reg     <= MAX_JUMP_RST;
            last_timer_reg   <= '0;
            last_step_reg    <= '0;
            turn_counter_reg <= TURN_RST;
        end else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_idx))
                    CFG_FULL_TURN: full_turn_reg <= cfg_data;
                    CFG_WRAP_THR:  wrap_thr_reg  <= cfg_data;
                    CFG_MIN_STEP:  min_step_reg  <= cfg_data;
                    CFG_MAX_JUMP:  max_jump_reg  <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        up_reg         <= up_in;
                        d_reg          <= d_in;
                        dt_reg         <= dt_in;
                        rev_reg        <= s_reverse;
                        last_timer_reg <= s_timer_now;
                        state_reg      <= S_STEP;
                    end
                end
                S_STEP: begin
                    step_reg <= step_in;
                    if (wrap) begin
                        turn_counter_reg <= up_reg ? turn_counter_reg + TURN_W'(1)
                                                   : turn_counter_reg - TURN_W'(1);
                    end
                    state_reg <= S_JUMP;
                end
                S_JUMP: begin
                    if (below) begin
                        speed_reg <= '0;
                        below_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        step_reg      <= step_sel;
                        last_step_reg <= step_sel;
                        below_reg     <= 1'b0;
                        state_reg     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    num_reg   <= NUM_W'(step_reg) * SPEED_GAIN;
                    den_reg   <= DEN_W'(dt_reg) + (DEN_W'(dt_reg) << 1);
                    rem_reg   <= '0;
                    cnt_reg   <= CNT_W'(NUM_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    num_reg <= num_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    speed_reg <= rev_reg ? -$signed(mag) : $signed(mag);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // one sample in flight: never ready for input while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_below_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_below_min |-> m_speed == '0)
        else $error("below-min result with nonzero speed");

    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed <= $signed(SPEED_MAX)) && (m_speed >= -$signed(SPEED_MAX)))
        else $error("speed outside saturation range");

    a_turn_only_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(state_reg) != S_STEP |-> $stable(turn_counter_reg))
        else $error("turn counter moved outside step phase");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOAD |=> state_reg == S_DIV && cnt_reg == CNT_W'(NUM_W - 1))
        else $error("divider not loaded with full count");

endmodule
